>>> sv/sbma_pkg.sv
// Shared types and constants for the span bitmap object allocator.
package sbma_pkg;

  // Layout constants
  localparam int PAGE_LOG2      = 13;
  localparam int ALIGN_BYTES    = 16;
  localparam int BITMAP_WORDS   = 64;
  localparam int MAX_SPAN_PAGES = 16;

  // Field and storage widths
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int OFFS_W   = 17;
  localparam int CNT_W    = 13;
  localparam int SIZE_W   = 18;
  localparam int PAGES_W  = 5;
  localparam int WORD_BITS = 64;
  localparam int BIT_W    = 6;
  localparam int WADDR_W  = 6;
  localparam int WORDS_W  = 7;
  localparam int TOTAL_W  = 18;
  localparam int DIV_W    = 21;

  // Configuration register indexes
  localparam logic REG_OBJ_BYTES  = 1'b0;
  localparam logic REG_SPAN_PAGES = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_NOP   = 2'd3
  } sbma_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_RANGE = 2'd3
  } sbma_status_e;

  // Divider operand selection
  typedef enum logic [1:0] {
    DSEL_EST  = 2'd0,
    DSEL_CAP  = 2'd1,
    DSEL_FREE = 2'd2
  } sbma_dsel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic         accept;
    logic         div_start;
    sbma_dsel_e   div_sel;
    logic         lay_words;
    logic         lay_cap;
    logic         lay_cap_zero;
    logic         clr_step;
    logic         scan_start;
    logic         scan_rd;
    logic         scan_take;
    logic         scan_next;
    logic         mul_load;
    logic         free_rd;
    logic         free_take;
    logic         out_load;
    sbma_status_e out_status;
    logic         out_alloc_ok;
  } sbma_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    sbma_func_e func;
    logic       div_done;
    logic       alloc_blocked;
    logic       free_low;
    logic       start_ge_total;
    logic       clr_last;
    logic       scan_hit;
    logic       scan_last;
    logic       free_big;
    logic       free_dup;
    logic       out_free;
  } sbma_sts_t;

endpackage

>>> sv/sbma_div.sv
// Restoring divider, one quotient bit per cycle.
module sbma_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sbma_pkg::DIV_W-1:0] dividend_i,
  input  logic [sbma_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [sbma_pkg::DIV_W-1:0] quotient_o
);
  import sbma_pkg::*;

  localparam int DCNT_W = $clog2(DIV_W);

  logic [DIV_W:0]     rem_q;
  logic [DIV_W-1:0]   quo_q;
  logic [DIV_W-1:0]   dvs_q;
  logic [DCNT_W-1:0]  cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DIV_W:0]     trial;
  logic               ge;

  // Shift in next dividend bit and try the subtraction
  assign trial = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
      quo_q <= {quo_q[DIV_W-2:0], ge};
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + DCNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/sbma_datapath.sv
// Allocator datapath: layout registers, bitmap memory, divider and result register.
module sbma_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbma_pkg::sbma_cmd_t          cmd_i,
  output sbma_pkg::sbma_sts_t          sts_o,
  input  logic [sbma_pkg::SIZE_W-1:0]  obj_bytes_i,
  input  logic [sbma_pkg::PAGES_W-1:0] span_pages_i,
  input  logic [sbma_pkg::FUNC_W-1:0]  s_func_i,
  input  logic [sbma_pkg::OFFS_W-1:0]  s_offset_i,
  input  logic                         m_tready_i,
  output logic                         m_tvalid_o,
  output logic [sbma_pkg::STAT_W-1:0]  m_status_o,
  output logic [sbma_pkg::OFFS_W-1:0]  m_alloc_offset_o,
  output logic [sbma_pkg::CNT_W-1:0]   m_used_o,
  output logic [sbma_pkg::CNT_W-1:0]   m_capacity_o
);
  import sbma_pkg::*;

  // Lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) r = BIT_W'(k);
    end
    return r;
  endfunction

  // Item and layout state
  sbma_func_e          func_q;
  logic [OFFS_W-1:0]   off_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cap_q;
  logic [OFFS_W-1:0]   start_q;
  logic [WORDS_W-1:0]  words_q;
  logic [WADDR_W-1:0]  scan_pos_q;
  logic [SIZE_W-1:0]   lsize_q;
  logic [WADDR_W-1:0]  clr_addr_q;
  logic [WADDR_W-1:0]  wp_q;
  logic [WORDS_W-1:0]  scan_i_q;
  logic [CNT_W-2:0]    idx_q;
  logic [OFFS_W-1:0]   prod_q;

  // Bitmap memory
  logic [WORD_BITS-1:0] mem_q [BITMAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 we;
  logic [WADDR_W-1:0]   waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 re;
  logic [WADDR_W-1:0]   raddr;

  // Result register
  logic                m_tvalid_q;
  logic [STAT_W-1:0]   m_status_q;
  logic [OFFS_W-1:0]   m_aoff_q;
  logic [CNT_W-1:0]    m_used_q;
  logic [CNT_W-1:0]    m_cap_q;

  // Divider
  logic [DIV_W-1:0]    dvd;
  logic [DIV_W-1:0]    dvs;
  logic                div_done;
  logic [DIV_W-1:0]    quot;

  // Layout arithmetic
  logic [PAGES_W-1:0]  pages_eff;
  logic [SIZE_W-1:0]   size_eff;
  logic [TOTAL_W-1:0]  total;
  logic [DIV_W-1:0]    wsum;
  logic [DIV_W-1:0]    wtmp;
  logic [WORDS_W-1:0]  words_calc;
  logic [OFFS_W-1:0]   st8;
  logic [OFFS_W-1:0]   start_calc;
  logic [CNT_W-1:0]    capmax;
  logic [CNT_W-1:0]    cap_calc;
  logic [WORDS_W-1:0]  full_words;
  logic [BIT_W-1:0]    tail_cnt;
  logic [WORD_BITS-1:0] clr_word;
  logic [BIT_W-1:0]    hit_bit;

  assign pages_eff = (span_pages_i > PAGES_W'(MAX_SPAN_PAGES)) ? PAGES_W'(MAX_SPAN_PAGES)
                                                                : span_pages_i;
  assign size_eff  = (obj_bytes_i == '0) ? SIZE_W'(1) : obj_bytes_i;
  assign total     = TOTAL_W'(pages_eff) << PAGE_LOG2;

  // Divider operands
  always_comb begin
    case (cmd_i.div_sel)
      DSEL_EST: begin
        dvd = {total, 3'b000};
        dvs = {size_eff, 3'b000} + DIV_W'(1);
      end
      DSEL_CAP: begin
        dvd = DIV_W'(total) - DIV_W'(start_q);
        dvs = DIV_W'(size_eff);
      end
      default: begin
        dvd = DIV_W'(off_q) - DIV_W'(start_q);
        dvs = DIV_W'(lsize_q);
      end
    endcase
  end

  sbma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Bitmap words and aligned data start from the estimate
  assign wsum       = quot + DIV_W'(WORD_BITS - 1);
  assign wtmp       = wsum >> BIT_W;
  assign words_calc = (wtmp > DIV_W'(BITMAP_WORDS)) ? WORDS_W'(BITMAP_WORDS)
                                                    : wtmp[WORDS_W-1:0];
  assign st8        = OFFS_W'(words_calc) << 3;
  assign start_calc = (st8 + OFFS_W'(ALIGN_BYTES - 1)) & ~OFFS_W'(ALIGN_BYTES - 1);

  // Capacity saturates at the bitmap size
  assign capmax   = CNT_W'(words_q) << BIT_W;
  assign cap_calc = (quot > DIV_W'(capmax)) ? capmax : quot[CNT_W-1:0];

  // Init pattern for one bitmap word
  assign full_words = cap_q[CNT_W-1:BIT_W];
  assign tail_cnt   = cap_q[BIT_W-1:0];
  always_comb begin
    if (WORDS_W'(clr_addr_q) < full_words) begin
      clr_word = '1;
    end else if (WORDS_W'(clr_addr_q) == full_words && tail_cnt != '0) begin
      clr_word = (WORD_BITS'(1) << tail_cnt) - WORD_BITS'(1);
    end else begin
      clr_word = '0;
    end
  end

  assign hit_bit = lowest_bit(rdata_q);

  // Memory port selection
  always_comb begin
    we    = cmd_i.clr_step | cmd_i.scan_take | cmd_i.free_take;
    waddr = quot[CNT_W-2:BIT_W];
    wdata = rdata_q | (WORD_BITS'(1) << quot[BIT_W-1:0]);
    if (cmd_i.clr_step) begin
      waddr = clr_addr_q;
      wdata = clr_word;
    end else if (cmd_i.scan_take) begin
      waddr = wp_q;
      wdata = rdata_q & ~(WORD_BITS'(1) << hit_bit);
    end
    re    = cmd_i.scan_rd | cmd_i.free_rd;
    raddr = cmd_i.scan_rd ? wp_q : quot[CNT_W-2:BIT_W];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // Item capture, scan pointers and product
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= sbma_func_e'(s_func_i);
      off_q  <= s_offset_i;
    end
    if (cmd_i.scan_start) begin
      wp_q     <= scan_pos_q;
      scan_i_q <= '0;
    end else if (cmd_i.scan_next) begin
      scan_i_q <= scan_i_q + WORDS_W'(1);
      wp_q     <= (WORDS_W'(wp_q) + WORDS_W'(1) == words_q) ? '0 : wp_q + WADDR_W'(1);
    end
    if (cmd_i.scan_take) idx_q <= {wp_q, hit_bit};
    if (cmd_i.mul_load) prod_q <= OFFS_W'(OFFS_W'(idx_q) * lsize_q[OFFS_W-1:0]);
  end

  // Layout and usage state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      cap_q      <= '0;
      start_q    <= '0;
      words_q    <= '0;
      scan_pos_q <= '0;
      lsize_q    <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.lay_words) begin
        words_q    <= words_calc;
        start_q    <= start_calc;
        lsize_q    <= size_eff;
        cnt_q      <= '0;
        scan_pos_q <= '0;
        clr_addr_q <= '0;
      end
      if (cmd_i.lay_cap) cap_q <= cap_calc;
      if (cmd_i.lay_cap_zero) cap_q <= '0;
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + WADDR_W'(1);
      if (cmd_i.scan_take) begin
        cnt_q      <= cnt_q + CNT_W'(1);
        scan_pos_q <= wp_q;
      end
      if (cmd_i.free_take && cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_status_q <= cmd_i.out_status;
      m_aoff_q   <= cmd_i.out_alloc_ok ? (start_q + prod_q) : '0;
      m_used_q   <= cnt_q;
      m_cap_q    <= cap_q;
    end
  end

  assign m_tvalid_o       = m_tvalid_q;
  assign m_status_o       = m_status_q;
  assign m_alloc_offset_o = m_aoff_q;
  assign m_used_o         = m_used_q;
  assign m_capacity_o     = m_cap_q;

  // Status to controller
  always_comb begin
    sts_o.func           = func_q;
    sts_o.div_done       = div_done;
    sts_o.alloc_blocked  = (cnt_q >= cap_q) || (words_q == '0);
    sts_o.free_low       = (off_q < start_q) || (lsize_q == '0);
    sts_o.start_ge_total = TOTAL_W'(start_q) >= total;
    sts_o.clr_last       = clr_addr_q == WADDR_W'(BITMAP_WORDS - 1);
    sts_o.scan_hit       = rdata_q != '0;
    sts_o.scan_last      = (scan_i_q + WORDS_W'(1)) == words_q;
    sts_o.free_big       = quot >= DIV_W'(cap_q);
    sts_o.free_dup       = rdata_q[quot[BIT_W-1:0]];
    sts_o.out_free       = !m_tvalid_q || m_tready_i;
  end

endmodule

>>> sv/sbma_ctrl.sv
// Allocator controller: sequences init, allocate and free operations.
module sbma_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  sbma_pkg::sbma_sts_t sts_i,
  output sbma_pkg::sbma_cmd_t cmd_o
);
  import sbma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EST,
    S_CAPCHK,
    S_CAPDIV,
    S_CLR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_FREE_DIV,
    S_FREE_CHK0,
    S_FREE_CHK,
    S_DONE
  } state_e;

  state_e       state_q, state_d;
  sbma_status_e status_q, status_d;
  logic         ok_q, ok_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ok_d     = ok_q;
    cmd_o    = '0;
    cmd_o.div_sel    = DSEL_FREE;
    cmd_o.out_status = status_q;
    cmd_o.out_alloc_ok = ok_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          ok_d     = 1'b0;
          status_d = STAT_OK;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.func)
          FUNC_INIT: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DSEL_EST;
            state_d = S_EST;
          end
          FUNC_ALLOC: begin
            if (sts_i.alloc_blocked) begin
              status_d = STAT_FULL;
              state_d  = S_DONE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN_RD;
            end
          end
          FUNC_FREE: begin
            if (sts_i.free_low) begin
              status_d = STAT_RANGE;
              state_d  = S_DONE;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d = S_FREE_DIV;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      // Layout: bitmap size estimate, then capacity
      S_EST: begin
        if (sts_i.div_done) begin
          cmd_o.lay_words = 1'b1;
          state_d = S_CAPCHK;
        end
      end
      S_CAPCHK: begin
        if (sts_i.start_ge_total) begin
          cmd_o.lay_cap_zero = 1'b1;
          state_d = S_CLR;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DSEL_CAP;
          state_d = S_CAPDIV;
        end
      end
      S_CAPDIV: begin
        cmd_o.div_sel = DSEL_CAP;
        if (sts_i.div_done) begin
          cmd_o.lay_cap = 1'b1;
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_DONE;
      end
      // Allocate: walk words from the cursor
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.scan_hit) begin
          cmd_o.scan_take = 1'b1;
          state_d = S_MUL;
        end else if (sts_i.scan_last) begin
          status_d = STAT_FULL;
          state_d  = S_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        ok_d    = 1'b1;
        state_d = S_DONE;
      end
      // Free: offset to index, then bit check
      S_FREE_DIV: begin
        if (sts_i.div_done) state_d = S_FREE_CHK0;
      end
      S_FREE_CHK0: begin
        if (sts_i.free_big) begin
          status_d = STAT_RANGE;
          state_d  = S_DONE;
        end else begin
          cmd_o.free_rd = 1'b1;
          state_d = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.free_dup) begin
          status_d = STAT_DUP;
        end else begin
          cmd_o.free_take = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= STAT_OK;
      ok_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      ok_q     <= ok_d;
    end
  end

  assign s_tready_o = state_q == S_IDLE;

endmodule

>>> sv/span_bitmap_object_allocator.sv
// Span bitmap object allocator top level: APB registers, controller and datapath.
// One item at a time; the steps of each operation follow.
// Free: serial divide of offset to index, then bit check; early range reject and no-op skip both.
// Allocate: reads bitmap words from the cursor (up to 64) until one holds a set bit.
// Init: one or two serial divides (estimate, then capacity) and a 64-word bitmap write sweep.
// Reset clears control and layout, not the bitmap; registers reset to size 64, 1 page.
module span_bitmap_object_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] free_offset, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [16:0] alloc_offset, [29:17] used_objects,
                                      // [42:30] object_capacity, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import sbma_pkg::*;

  logic [SIZE_W-1:0]  obj_bytes_q;
  logic [PAGES_W-1:0] span_pages_q;
  sbma_cmd_t          cmd;
  sbma_sts_t          sts;
  logic [OFFS_W-1:0]  aoff;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   cap;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_bytes_q  <= SIZE_W'(64);
      span_pages_q <= PAGES_W'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_OBJ_BYTES:  obj_bytes_q  <= pwdata[SIZE_W-1:0];
        REG_SPAN_PAGES: span_pages_q <= pwdata[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPAN_PAGES) ? 32'(span_pages_q) : 32'(obj_bytes_q);

  sbma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbma_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .obj_bytes_i      (obj_bytes_q),
    .span_pages_i     (span_pages_q),
    .s_func_i         (s_axis_tuser),
    .s_offset_i       (s_axis_tdata[OFFS_W-1:0]),
    .m_tready_i       (m_axis_tready),
    .m_tvalid_o       (m_axis_tvalid),
    .m_status_o       (m_axis_tuser),
    .m_alloc_offset_o (aoff),
    .m_used_o         (used),
    .m_capacity_o     (cap)
  );

  assign m_axis_tdata = {5'b0, cap, used, aoff};

endmodule
